### hw/rtl/atncs_pkg.sv
// atncs_pkg: shared constants and the log2 fraction function for the ant tour next-city selector
// no dependencies
package atncs_pkg;

  localparam int unsigned LOG_INT_BITS = 6;
  localparam logic [23:0] PHER_BONUS = 24'd1000;
  localparam logic [23:0] MASK24 = 24'hFFFFFF;

  localparam logic [1:0] CFG_ALPHA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_CITIES = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_ROW   = 1'b1;

  // first fbits bits of log2(1 + k/256), repeated squaring of a Q1.30 mantissa
  function automatic logic [13:0] frac_entry(input logic [7:0] k, input int unsigned fbits);
    logic [63:0] m;
    logic [13:0] f;
    begin
      m = {46'd0, 1'b1, k, 9'd0} << 13;
      f = '0;
      for (int b = 0; b < 14; b++) begin
        if (b < fbits) begin
          m = (m * m) >> 30;
          f = {f[12:0], 1'b0};
          if (m >= (64'd1 << 31)) begin
            f[0] = 1'b1;
            m = m >> 1;
          end
        end
      end
      return f;
    end
  endfunction

endpackage

### hw/rtl/atncs_if.sv
// atncs_if: valid/ready channel interfaces for input, result and configuration
// depends on nothing
interface atncs_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  start_index;
  logic [23:0] pher_value;
  logic [15:0] dist_value;
  modport source (output valid, req_type, start_index, pher_value, dist_value, input ready);
  modport sink (input valid, req_type, start_index, pher_value, dist_value, output ready);
endinterface

interface atncs_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  next_index;
  logic [23:0] pher_updated;
  logic [15:0] step_dist;
  logic [23:0] tour_total;
  logic        tour_done;
  modport source (output valid, next_index, pher_updated, step_dist, tour_total, tour_done,
                  input ready);
  modport sink (input valid, next_index, pher_updated, step_dist, tour_total, tour_done,
                output ready);
endinterface

interface atncs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ant_tour_next_city_select_top.sv
// Ant tour next-city selector. Takes one item per cycle unless a held result waits on res.ready:
// a start item (req_type 0) or one row candidate. The last candidate of a row passes the input
// stage register and the back stage, which gives the row's result; an output register decouples results.
// depends on atncs_pkg, atncs_if, atncs_front, atncs_back
module ant_tour_next_city_select_top
  import atncs_pkg::*;
#(
  parameter int unsigned MAX_CITIES = 256,
  parameter int unsigned LOG_FRAC_BITS = 10
) (
  input logic clk_i,
  input logic rst_ni,
  atncs_req_if.sink   req,
  atncs_res_if.source res,
  atncs_cfg_if.sink   cfg
);
  localparam int unsigned LW = LOG_INT_BITS + LOG_FRAC_BITS;
  localparam int unsigned CAP = (MAX_CITIES < 256) ? MAX_CITIES : 256;

  logic [3:0] alpha_q, beta_q;
  logic [8:0] cities_q, lim;

  // input stage register (queue of one)
  logic q_vld_q;
  logic q_type_q;
  logic [7:0] q_sidx_q;
  logic [23:0] q_pher_q;
  logic [15:0] q_dist_q;
  logic [LW-1:0] lp, ld, lp_q, ld_q;

  logic o_vld_q;
  logic b_vld;
  logic [7:0] b_idx;
  logic [23:0] b_pher, b_tot;
  logic [15:0] b_dist;
  logic b_done;
  logic adv;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 4'd1; beta_q <= 4'd1; cities_q <= 9'd256;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ALPHA: alpha_q <= cfg.data[3:0];
        CFG_BETA: beta_q <= cfg.data[3:0];
        CFG_CITIES: cities_q <= cfg.data;
        default: ;
      endcase
    end
  end

  assign lim = (cities_q < 9'd2) ? 9'd2 : ((cities_q > 9'(CAP)) ? 9'(CAP) : cities_q);

  atncs_front #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_front (
    .pher_i(req.pher_value), .dist_i(req.dist_value), .lp_o(lp), .ld_o(ld)
  );

  // back stage may fire only if its possible result has room
  assign adv = q_vld_q && (!o_vld_q || res.ready);
  assign req.ready = !q_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q_vld_q <= 1'b0;
    else if (req.ready) q_vld_q <= req.valid;
  end
  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      q_type_q <= req.req_type; q_sidx_q <= req.start_index;
      q_pher_q <= req.pher_value; q_dist_q <= req.dist_value;
      lp_q <= lp; ld_q <= ld;
    end
  end

  atncs_back #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .vld_i(adv), .start_i(q_type_q == REQ_START),
    .start_idx_i(q_sidx_q), .pher_i(q_pher_q), .dist_i(q_dist_q), .lp_i(lp_q), .ld_i(ld_q),
    .alpha_i(alpha_q), .beta_i(beta_q), .lim_i(lim), .res_vld_o(b_vld), .res_idx_o(b_idx),
    .res_pher_o(b_pher), .res_dist_o(b_dist), .res_tot_o(b_tot), .res_done_o(b_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else if (b_vld) o_vld_q <= 1'b1;
    else if (res.ready) o_vld_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (b_vld) begin
      res.next_index <= b_idx; res.pher_updated <= b_pher; res.step_dist <= b_dist;
      res.tour_total <= b_tot; res.tour_done <= b_done;
    end
  end
  assign res.valid = o_vld_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) b_vld |-> adv)
    else $error("result without accepted item");
  assert property (@(posedge clk_i) disable iff (!rst_ni) o_vld_q && !res.ready |-> !b_vld)
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni) lim >= 9'd2 && lim <= 9'(CAP))
    else $error("city limit out of range");
endmodule

### hw/rtl/atncs_front.sv
// atncs_front: computes candidate score terms (log2 of pheromone and distance)
// depends on atncs_pkg
module atncs_front
  import atncs_pkg::*;
#(
  parameter int unsigned LOG_FRAC_BITS = 10
) (
  input  logic [23:0] pher_i,
  input  logic [15:0] dist_i,
  output logic [LOG_INT_BITS+LOG_FRAC_BITS-1:0] lp_o,
  output logic [LOG_INT_BITS+LOG_FRAC_BITS-1:0] ld_o
);
  localparam int unsigned LW = LOG_INT_BITS + LOG_FRAC_BITS;
  localparam int unsigned TW = 256 * LOG_FRAC_BITS;

  // fraction table, filled at elaboration
  function automatic logic [TW-1:0] build_frac_tab();
    logic [TW-1:0] t;
    logic [13:0] f;
    begin
      t = '0;
      for (int k = 0; k < 256; k++) begin
        f = frac_entry(8'(k), LOG_FRAC_BITS);
        t[k*LOG_FRAC_BITS +: LOG_FRAC_BITS] = f[LOG_FRAC_BITS-1:0];
      end
      return t;
    end
  endfunction

  localparam logic [TW-1:0] FRAC_TAB = build_frac_tab();

  function automatic logic [LW-1:0] log2f(input logic [23:0] v);
    logic [4:0] e;
    logic [31:0] w;
    logic [7:0] k;
    begin
      e = '0;
      for (int i = 1; i < 24; i++) begin
        if (v[i]) e = 5'(i);
      end
      w = {8'd0, v} << 8;
      k = w[e +: 8];
      return LW'({e, {LOG_FRAC_BITS{1'b0}}}) |
             LW'(FRAC_TAB[k*LOG_FRAC_BITS +: LOG_FRAC_BITS]);
    end
  endfunction

  assign lp_o = log2f(pher_i);
  assign ld_o = log2f({8'd0, dist_i});
endmodule

### hw/rtl/atncs_back.sv
// atncs_back: divides the log terms, tracks the running best and the visited map
// depends on atncs_pkg
module atncs_back
  import atncs_pkg::*;
#(
  parameter int unsigned LOG_FRAC_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic        vld_i,
  input  logic        start_i,
  input  logic [7:0]  start_idx_i,
  input  logic [23:0] pher_i,
  input  logic [15:0] dist_i,
  input  logic [LOG_INT_BITS+LOG_FRAC_BITS-1:0] lp_i,
  input  logic [LOG_INT_BITS+LOG_FRAC_BITS-1:0] ld_i,
  input  logic [3:0]  alpha_i,
  input  logic [3:0]  beta_i,
  input  logic [8:0]  lim_i,
  output logic        res_vld_o,
  output logic [7:0]  res_idx_o,
  output logic [23:0] res_pher_o,
  output logic [15:0] res_dist_o,
  output logic [23:0] res_tot_o,
  output logic        res_done_o
);
  localparam int unsigned LW = LOG_INT_BITS + LOG_FRAC_BITS;
  localparam int unsigned SW = LW + 1;
  localparam logic signed [SW-1:0] SCORE_MIN = {1'b1, {LW{1'b0}}};
  localparam int unsigned RS = LW + 4;
  localparam int unsigned RW = RS + 1;

  // rounded-up reciprocals of the divisors 1 to 15, exact for any LW-bit dividend
  function automatic logic [16*RW-1:0] build_recip();
    logic [16*RW-1:0] t;
    longint unsigned r;
    begin
      t = '0;
      for (int d = 1; d < 16; d++) begin
        r = ((64'd1 << RS) + 64'(d) - 64'd1) / 64'(d);
        t[d*RW +: RW] = RW'(r);
      end
      return t;
    end
  endfunction

  localparam logic [16*RW-1:0] RECIP_TAB = build_recip();

  logic [255:0] vis_q, vis_d;
  logic [7:0] org_q, org_d;
  logic [8:0] cnt_q, cnt_d;
  logic signed [SW-1:0] bs_q, bs_d;
  logic [7:0] bi_q, bi_d;
  logic [23:0] bp_q, bp_d;
  logic [15:0] bd_q, bd_d;
  logic any_q, any_d;
  logic [23:0] sum_q, sum_d;

  logic [3:0] ad, bd;
  logic [RW-1:0] ra, rb;
  logic [LW+RS-1:0] pa, pb;
  logic [LW-1:0] qa, qb;
  logic signed [SW-1:0] score;
  logic elig, last;
  logic [24:0] p_sum, t_sum;

  assign ad = (alpha_i == 4'd0) ? 4'd1 : alpha_i;
  assign bd = (beta_i == 4'd0) ? 4'd1 : beta_i;

  assign ra = RECIP_TAB[ad*RW +: RW];
  assign rb = RECIP_TAB[bd*RW +: RW];
  assign pa = lp_i * ra;
  assign pb = ld_i * rb;
  assign qa = pa[LW+RS-1:RS];
  assign qb = pb[LW+RS-1:RS];
  assign score = (pher_i == 24'd0) ? SCORE_MIN
               : $signed({1'b0, qa}) - $signed({1'b0, qb});
  assign elig = !vis_q[cnt_q[7:0]] && (dist_i != 16'd0);
  assign last = (cnt_q + 9'd1) >= lim_i;

  always_comb begin
    vis_d = vis_q; org_d = org_q; cnt_d = cnt_q; bs_d = bs_q; bi_d = bi_q;
    bp_d = bp_q; bd_d = bd_q; any_d = any_q; sum_d = sum_q;
    p_sum = '0;
    t_sum = '0;
    res_vld_o = 1'b0;
    res_idx_o = org_q;
    res_pher_o = '0;
    res_dist_o = '0;
    res_tot_o = sum_q;
    res_done_o = 1'b1;
    if (vld_i && start_i) begin
      if ({1'b0, start_idx_i} < lim_i) begin
        vis_d = '0;
        vis_d[start_idx_i] = 1'b1;
        org_d = start_idx_i;
        sum_d = '0;
        cnt_d = '0; bs_d = SCORE_MIN; bi_d = '0; bp_d = '0; bd_d = '0; any_d = 1'b0;
      end
    end else if (vld_i) begin
      if (elig && (!any_q || score >= bs_q)) begin
        bs_d = score; bi_d = cnt_q[7:0]; bp_d = pher_i; bd_d = dist_i; any_d = 1'b1;
      end
      cnt_d = cnt_q + 9'd1;
      if (last) begin
        res_vld_o = 1'b1;
        if (any_d) begin
          p_sum = {1'b0, bp_d} + {1'b0, PHER_BONUS};
          t_sum = {1'b0, sum_q} + {9'd0, bd_d};
          res_idx_o = bi_d;
          res_pher_o = p_sum[24] ? MASK24 : p_sum[23:0];
          res_dist_o = bd_d;
          res_tot_o = t_sum[24] ? MASK24 : t_sum[23:0];
          res_done_o = 1'b0;
          sum_d = res_tot_o;
          vis_d[bi_d] = 1'b1;
        end
        cnt_d = '0; bs_d = SCORE_MIN; bi_d = '0; bp_d = '0; bd_d = '0; any_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0; org_q <= '0; cnt_q <= '0; bs_q <= SCORE_MIN; bi_q <= '0;
      bp_q <= '0; bd_q <= '0; any_q <= 1'b0; sum_q <= '0;
    end else begin
      vis_q <= vis_d; org_q <= org_d; cnt_q <= cnt_d; bs_q <= bs_d; bi_q <= bi_d;
      bp_q <= bp_d; bd_q <= bd_d; any_q <= any_d; sum_q <= sum_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !any_q |-> bs_q == SCORE_MIN)
    else $error("best score set without eligible candidate");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 9'd256)
    else $error("candidate count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && !res_done_o |=> vis_q[$past(res_idx_o)])
    else $error("chosen city not marked visited");
endmodule

### tb/tb.sv
// tb: self-checking testbench for ant_tour_next_city_select_top
// predicts each next-city choice from the row stream and checks every result transaction
// depends on atncs_pkg, atncs_if and the selector rtl
module tb;
  import atncs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [7:0]  start;
    logic [23:0] pher;
    logic [15:0] span;
  } cand_item_t;

  typedef struct packed {
    logic [7:0]  city;
    logic [23:0] pher;
    logic [15:0] span;
    logic [23:0] total;
    logic        done;
  } hop_t;

  typedef struct packed {
    logic [1:0] idx;
    logic [8:0] val;
  } reg_wr_t;

  localparam int FRAC_W = 10;
  localparam int SCORE_FLOOR = -65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  atncs_req_if req ();
  atncs_res_if res ();
  atncs_cfg_if cfg ();

  ant_tour_next_city_select_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .res   (res),
    .cfg   (cfg)
  );

  cand_item_t item_q[$];
  reg_wr_t    reg_q[$];
  hop_t       hop_exp_q[$];

  int cycle_cnt = 0;
  int fail_cnt = 0;
  int hop_cnt = 0;
  int done_cnt = 0;
  int items_sent = 0;

  // predictor state
  logic [3:0]  a_div = 4'd1;
  logic [3:0]  b_div = 4'd1;
  logic [8:0]  n_cities = 9'd256;
  logic        seen[256];
  logic [7:0]  cur_city = '0;
  logic [7:0]  home_city = '0;
  int          cand_n = 0;
  int          top_score = SCORE_FLOOR;
  logic [7:0]  top_idx = '0;
  logic [23:0] top_pher = '0;
  logic [15:0] top_dist = '0;
  logic        have_top = 1'b0;
  logic [23:0] trip_sum = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("ant_tour_next_city_select_top: mismatch");
    $finish;
  end

  function automatic int log2_q(input logic [31:0] v);
    int          e;
    logic [7:0]  k;
    logic [63:0] mant;
    int          frac;
    e = 0;
    for (int i = 0; i < 32; i++) if (v[i]) e = i;
    k = (e >= 8) ? 8'(v >> (e - 8)) : 8'(v << (8 - e));
    mant = 64'(256 + k) << 22;
    frac = 0;
    for (int b = 0; b < FRAC_W; b++) begin
      mant = (mant * mant) >> 30;
      frac = frac * 2;
      if (mant >= (64'd1 << 31)) begin
        frac = frac + 1;
        mant = mant >> 1;
      end
    end
    return (e << FRAC_W) + frac;
  endfunction

  function automatic int eff_cities();
    int n;
    n = n_cities;
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    return n;
  endfunction

  function automatic void clear_best();
    cand_n = 0;
    top_score = SCORE_FLOOR;
    top_idx = '0;
    top_pher = '0;
    top_dist = '0;
    have_top = 1'b0;
  endfunction

  function automatic void predict_hop(input cand_item_t it);
    int          n;
    int          ad;
    int          bd;
    int          sc;
    logic [7:0]  ci;
    int          p;
    int          t;
    hop_t        h;
    n = eff_cities();
    if (it.kind == REQ_START) begin
      if (it.start >= n) return;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[it.start] = 1'b1;
      cur_city = it.start;
      home_city = it.start;
      trip_sum = '0;
      clear_best();
      return;
    end
    ci = 8'(cand_n);
    if (!seen[ci] && it.span != 0) begin
      ad = (a_div == 0) ? 1 : a_div;
      bd = (b_div == 0) ? 1 : b_div;
      if (it.pher == 0) sc = SCORE_FLOOR;
      else sc = log2_q(it.pher) / ad - log2_q(it.span) / bd;
      if (!have_top || sc >= top_score) begin
        top_score = sc;
        top_idx = ci;
        top_pher = it.pher;
        top_dist = it.span;
        have_top = 1'b1;
      end
    end
    cand_n++;
    if (cand_n < n) return;
    if (have_top) begin
      p = top_pher + 1000;
      t = trip_sum + top_dist;
      if (p > 24'hFFFFFF) p = 24'hFFFFFF;
      if (t > 24'hFFFFFF) t = 24'hFFFFFF;
      trip_sum = 24'(t);
      seen[top_idx] = 1'b1;
      cur_city = top_idx;
      h = '{city: top_idx, pher: 24'(p), span: top_dist, total: 24'(t), done: 1'b0};
    end else begin
      cur_city = home_city;
      h = '{city: home_city, pher: '0, span: '0, total: trip_sum, done: 1'b1};
    end
    hop_exp_q.push_back(h);
    clear_best();
  endfunction

  function automatic logic idle_roll();
    if (cycle_cnt >= 2000 && cycle_cnt < 2600) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.req_type <= REQ_START;
      req.start_index <= '0;
      req.pher_value <= '0;
      req.dist_value <= '0;
    end else if (!req.valid || req.ready) begin
      if (item_q.size() > 0 && !idle_roll()) begin
        cand_item_t it;
        it = item_q.pop_front();
        req.valid <= 1'b1;
        req.req_type <= it.kind;
        req.start_index <= it.start;
        req.pher_value <= it.pher;
        req.dist_value <= it.span;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.valid <= 1'b0;
      cfg.index <= CFG_ALPHA;
      cfg.data <= '0;
    end else if (!cfg.valid || cfg.ready) begin
      if (reg_q.size() > 0) begin
        reg_wr_t w;
        w = reg_q.pop_front();
        cfg.valid <= 1'b1;
        cfg.index <= w.idx;
        cfg.data <= w.val;
      end else begin
        cfg.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res.ready <= 1'b0;
    else res.ready <= !idle_roll();
  end

  // monitor and checker
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        hop_t got;
        hop_t want;
        got = '{city: res.next_index, pher: res.pher_updated, span: res.step_dist,
                total: res.tour_total, done: res.tour_done};
        if (hop_exp_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_cnt++;
        end else begin
          want = hop_exp_q.pop_front();
          hop_cnt++;
          if (want.done) done_cnt++;
          if (got.city !== want.city)
            $display("%0t: next_index exp %0d got %0d", $time, want.city, got.city);
          if (got.pher !== want.pher)
            $display("%0t: pher_updated exp %0d got %0d", $time, want.pher, got.pher);
          if (got.span !== want.span)
            $display("%0t: step_dist exp %0d got %0d", $time, want.span, got.span);
          if (got.total !== want.total)
            $display("%0t: tour_total exp %0d got %0d", $time, want.total, got.total);
          if (got.done !== want.done)
            $display("%0t: tour_done exp %0b got %0b", $time, want.done, got.done);
          if (got !== want) fail_cnt++;
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_ALPHA:  a_div = cfg.data[3:0];
          CFG_BETA:   b_div = cfg.data[3:0];
          CFG_CITIES: n_cities = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        predict_hop('{kind: req.req_type, start: req.start_index,
                      pher: req.pher_value, span: req.dist_value});
        items_sent++;
      end
    end
  end

  task automatic settle();
    do @(negedge clk_i);
    while (item_q.size() != 0 || reg_q.size() != 0 || req.valid || cfg.valid ||
           hop_exp_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_regs(input int a, input int b, input int n);
    settle();
    reg_q.push_back('{idx: CFG_ALPHA, val: 9'(a)});
    reg_q.push_back('{idx: CFG_BETA, val: 9'(b)});
    reg_q.push_back('{idx: CFG_CITIES, val: 9'(n)});
    settle();
  endtask

  task automatic push_start(input int s);
    item_q.push_back('{kind: REQ_START, start: 8'(s), pher: '0, span: '0});
  endtask

  task automatic push_cand(input logic [23:0] p, input logic [15:0] d);
    item_q.push_back('{kind: REQ_ROW, start: 8'($urandom), pher: p, span: d});
  endtask

  function automatic logic [23:0] rand_pher();
    case ($urandom_range(9))
      0: return '0;
      1: return 24'hFFFFFF;
      2, 3, 4: return 24'($urandom_range(1, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_dist();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_rows(input int rows, input int n);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < n; c++) push_cand(rand_pher(), rand_dist());
  endtask

  initial begin
    int n;
    int big_left;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: four cities, extremes, zero pheromone, no edge, ties
    set_regs(1, 1, 4);
    push_start(0);
    push_cand(24'd5, 16'd9);
    push_cand(24'd0, 16'd1);
    push_cand(24'hFFFFFF, 16'hFFFF);
    push_cand(24'd1, 16'd0);
    push_cand(24'd7, 16'd3);
    push_cand(24'd7, 16'd3);
    push_cand(24'd7, 16'd3);
    push_cand(24'd7, 16'd3);
    push_rows(3, 4);
    push_start(9);
    push_start(3);
    push_cand(24'd20, 16'd2);
    push_start(1);
    push_rows(1, 4);
    set_regs(15, 15, 4);
    push_start(2);
    push_rows(1, 4);
    set_regs(0, 0, 0);
    push_start(1);
    push_rows(2, 2);
    // city count lowered mid-row
    set_regs(2, 3, 8);
    push_start(0);
    push_cand(24'd100, 16'd4);
    push_cand(24'd300, 16'd5);
    push_cand(24'd0, 16'd6);
    set_regs(2, 3, 2);
    push_cand(24'd9, 16'd9);
    push_rows(1, 2);
    set_regs(1, 1, 511);
    push_start(255);
    push_rows(1, 256);

    big_left = 1;
    while (items_sent + item_q.size() < 720) begin
      n = $urandom_range(2, 8);
      case ($urandom_range(19))
        0: n = 0;
        1: n = 1;
        2: if (big_left > 0) begin
          n = 256;
          big_left--;
        end
        default: ;
      endcase
      set_regs($urandom_range(0, 15), $urandom_range(0, 15), n);
      n = eff_cities();
      for (int t = $urandom_range(1, 3); t > 0; t--) begin
        if ($urandom_range(9) == 0) push_start($urandom_range(n, 255) % 256);
        if ($urandom_range(9) == 0) begin
          push_start($urandom_range(n - 1));
          push_rows(1, $urandom_range(n - 1) % n);
        end
        push_start($urandom_range(n - 1));
        push_rows((n == 256) ? 1 : $urandom_range(1, n + 1), n);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d input items, %0d results checked, %0d of them tour ends",
             items_sent, hop_cnt, done_cnt);
    if (fail_cnt == 0 && hop_exp_q.size() == 0) begin
      $display("ant_tour_next_city_select_top: match");
    end else begin
      $display("ant_tour_next_city_select_top: mismatch");
    end
    $finish;
  end

endmodule
